@@ src/cbpg_pkg.sv @@
// Shared types and constants of the cubic Bezier point generator.
`timescale 1ns / 1ps

package cbpg_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int ResBits   = CoordBits + FracBits;
  localparam int TBits     = 16;
  localparam int CountBits = 7;
  localparam int IndexBits = 6;

  typedef logic signed [ResBits-1:0] coord_t;
  typedef logic [TBits-1:0] frac_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] p0_x;
    logic signed [CoordBits-1:0] p0_y;
    logic signed [CoordBits-1:0] p1_x;
    logic signed [CoordBits-1:0] p1_y;
    logic signed [CoordBits-1:0] p2_x;
    logic signed [CoordBits-1:0] p2_y;
    logic signed [CoordBits-1:0] p3_x;
    logic signed [CoordBits-1:0] p3_y;
    logic [CountBits-1:0]        point_count;
  } cbpg_in_t;

  typedef struct packed {
    coord_t               out_x;
    coord_t               out_y;
    logic [IndexBits-1:0] point_index;
    logic                 last_point;
  } cbpg_out_t;

  typedef struct packed {
    logic                 valid;
    logic [IndexBits-1:0] index;
    logic                 last;
  } cbpg_meta_t;

endpackage

@@ src/cbpg_seq.sv @@
// Point sequencer: steps k through a curve and tracks t = floor(k * 2^16 / n).
`timescale 1ns / 1ps

module cbpg_seq
  import cbpg_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [CountBits-1:0] count_i,
  output logic                 busy_o,
  output frac_t                t_o,
  output cbpg_meta_t           meta_o
);

  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int StepW = TBits + 1;
  localparam int unsigned TOne = 1 << TBits;

  logic [StepW-1:0] step_tab [MAX_POINTS];
  logic [CntW-1:0]  rem_tab  [MAX_POINTS];

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_tab
    localparam int unsigned StepVal = TOne / (g + 1);
    localparam int unsigned RemVal  = TOne % (g + 1);
    assign step_tab[g] = StepW'(StepVal);
    assign rem_tab[g]  = CntW'(RemVal);
  end

  logic             active_q, active_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [StepW-1:0] acc_q, acc_d;
  logic [CntW-1:0]  r_q, r_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  rem_q, rem_d;

  logic [CntW-1:0]  n_sat;
  logic [CntW-1:0]  n_m1;
  logic [IdxW-1:0]  tab_idx;
  logic [CntW:0]    r_sum;
  logic             seq_last;

  always_comb begin
    n_sat    = (count_i > CountBits'(MAX_POINTS)) ? CntW'(MAX_POINTS) : CntW'(count_i);
    n_m1     = n_sat - 1'b1;
    tab_idx  = n_m1[IdxW-1:0];
    seq_last = (k_q == CntW'(n_q - 1'b1));
    r_sum    = {1'b0, r_q} + {1'b0, rem_q};

    active_d = active_q;
    k_d      = k_q;
    n_d      = n_q;
    acc_d    = acc_q;
    r_d      = r_q;
    step_d   = step_q;
    rem_d    = rem_q;

    if (load_i) begin
      active_d = (n_sat != '0);
      k_d      = '0;
      n_d      = n_sat;
      acc_d    = '0;
      r_d      = '0;
      step_d   = step_tab[tab_idx];
      rem_d    = rem_tab[tab_idx];
    end else if (active_q) begin
      if (seq_last) begin
        active_d = 1'b0;
      end else begin
        k_d = k_q + 1'b1;
        if (r_sum >= {1'b0, n_q}) begin
          acc_d = acc_q + step_q + StepW'(1);
          r_d   = CntW'(r_sum - {1'b0, n_q});
        end else begin
          acc_d = acc_q + step_q;
          r_d   = CntW'(r_sum);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
      n_q      <= '0;
      acc_q    <= '0;
      r_q      <= '0;
      step_q   <= '0;
      rem_q    <= '0;
    end else begin
      active_q <= active_d;
      k_q      <= k_d;
      n_q      <= n_d;
      acc_q    <= acc_d;
      r_q      <= r_d;
      step_q   <= step_d;
      rem_q    <= rem_d;
    end
  end

  always_comb begin
    busy_o       = active_q & ~seq_last;
    t_o          = acc_q[TBits-1:0];
    meta_o.valid = active_q;
    meta_o.index = IndexBits'(k_q);
    meta_o.last  = seq_last;
  end

endmodule

@@ src/cbpg_lerp.sv @@
// One interpolation level: a multiply stage and an add stage for x and y.
`timescale 1ns / 1ps

module cbpg_lerp
  import cbpg_pkg::*;
#(
  parameter int N_OUT = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  coord_t     x_i [N_OUT+1],
  input  coord_t     y_i [N_OUT+1],
  input  frac_t      t_i,
  input  cbpg_meta_t meta_i,
  output coord_t     x_o [N_OUT],
  output coord_t     y_o [N_OUT],
  output frac_t      t_o,
  output cbpg_meta_t meta_o
);

  localparam int DiffW = ResBits + 1;
  localparam int MulW  = DiffW + TBits + 1;

  function automatic logic signed [MulW-1:0] scaled(coord_t a, coord_t b, frac_t t);
    logic signed [DiffW-1:0] d;
    logic signed [TBits:0]   ts;
    d  = DiffW'(b) - DiffW'(a);
    ts = {1'b0, t};
    return d * ts;
  endfunction

  function automatic coord_t settle(coord_t a, logic signed [MulW-1:0] p);
    logic [DiffW-1:0] s;
    s = DiffW'(a) + p[TBits +: DiffW];
    return s[ResBits-1:0];
  endfunction

  logic signed [MulW-1:0] px_d [N_OUT];
  logic signed [MulW-1:0] py_d [N_OUT];
  logic signed [MulW-1:0] px_q [N_OUT];
  logic signed [MulW-1:0] py_q [N_OUT];
  coord_t                 bx_q [N_OUT];
  coord_t                 by_q [N_OUT];
  coord_t                 x_q  [N_OUT];
  coord_t                 y_q  [N_OUT];
  frac_t                  t1_q;
  frac_t                  t2_q;
  cbpg_meta_t             m1_q;
  cbpg_meta_t             m2_q;

  always_comb begin
    for (int j = 0; j < N_OUT; j++) begin
      px_d[j] = scaled(x_i[j], x_i[j+1], t_i);
      py_d[j] = scaled(y_i[j], y_i[j+1], t_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < N_OUT; j++) begin
      px_q[j] <= px_d[j];
      py_q[j] <= py_d[j];
      bx_q[j] <= x_i[j];
      by_q[j] <= y_i[j];
      x_q[j]  <= settle(bx_q[j], px_q[j]);
      y_q[j]  <= settle(by_q[j], py_q[j]);
    end
    t1_q <= t_i;
    t2_q <= t1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
    end else begin
      m1_q <= meta_i;
      m2_q <= m1_q;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign t_o    = t2_q;
  assign meta_o = m2_q;

endmodule

@@ src/cubic_bezier_point_generator_core.sv @@
// The first point of an accepted curve passes the sequencer register and the six lerp stages before it appears.
// Throughput: one point per cycle; a curve of zero points issues none.
// Busy falls when the last point of a curve issues, so the next curve is accepted as that point issues.
// The sequencer issues one t per cycle into a six-stage lerp pipeline (two stages per level).
// Reset is asynchronous and active low; it clears the sequencer and all valid bits.
`timescale 1ns / 1ps

module cubic_bezier_point_generator_core
  import cbpg_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  cbpg_in_t  curve_i,
  output logic      point_valid_o,
  output cbpg_out_t point_o
);

  logic       load;
  frac_t      t0;
  frac_t      t1;
  frac_t      t2;
  cbpg_meta_t m0;
  cbpg_meta_t m1;
  cbpg_meta_t m2;
  cbpg_meta_t m3;

  coord_t cx_q [4];
  coord_t cy_q [4];
  coord_t qx [3];
  coord_t qy [3];
  coord_t rx [2];
  coord_t ry [2];
  coord_t sx [1];
  coord_t sy [1];

  assign load = start & ~busy;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cx_q[0] <= {curve_i.p0_x, {FracBits{1'b0}}};
      cy_q[0] <= {curve_i.p0_y, {FracBits{1'b0}}};
      cx_q[1] <= {curve_i.p1_x, {FracBits{1'b0}}};
      cy_q[1] <= {curve_i.p1_y, {FracBits{1'b0}}};
      cx_q[2] <= {curve_i.p2_x, {FracBits{1'b0}}};
      cy_q[2] <= {curve_i.p2_y, {FracBits{1'b0}}};
      cx_q[3] <= {curve_i.p3_x, {FracBits{1'b0}}};
      cy_q[3] <= {curve_i.p3_y, {FracBits{1'b0}}};
    end
  end

  cbpg_seq #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .count_i(curve_i.point_count),
    .busy_o (busy),
    .t_o    (t0),
    .meta_o (m0)
  );

  cbpg_lerp #(
    .N_OUT(3)
  ) u_lerp1 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .x_i   (cx_q),
    .y_i   (cy_q),
    .t_i   (t0),
    .meta_i(m0),
    .x_o   (qx),
    .y_o   (qy),
    .t_o   (t1),
    .meta_o(m1)
  );

  cbpg_lerp #(
    .N_OUT(2)
  ) u_lerp2 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .x_i   (qx),
    .y_i   (qy),
    .t_i   (t1),
    .meta_i(m1),
    .x_o   (rx),
    .y_o   (ry),
    .t_o   (t2),
    .meta_o(m2)
  );

  cbpg_lerp #(
    .N_OUT(1)
  ) u_lerp3 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .x_i   (rx),
    .y_i   (ry),
    .t_i   (t2),
    .meta_i(m2),
    .x_o   (sx),
    .y_o   (sy),
    .t_o   (),
    .meta_o(m3)
  );

  always_comb begin
    point_valid_o       = m3.valid;
    point_o.out_x       = sx[0];
    point_o.out_y       = sy[0];
    point_o.point_index = m3.index;
    point_o.last_point  = m3.last;
  end

`ifndef ASSERT_OFF
  a_first_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (curve_i.point_count != '0)
    |-> ##7 (point_valid_o && (point_o.point_index == '0)))
    else $error("first point of an accepted curve did not appear on time");

  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !point_o.last_point |=> point_valid_o)
    else $error("gap inside the points of one curve");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !point_o.last_point
    |=> (point_o.point_index == IndexBits'($past(point_o.point_index) + 1'b1)))
    else $error("point index did not advance by one");
`endif

endmodule
